// ===== design/sliding_window_median_filter_macros.svh =====
// Assertion helpers for the filter RTL.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_MACROS_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_MACROS_SVH

`ifndef SYNTH
// antecedent holds -> consequent holds in the same cycle
`define SWMF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swmf assertion failed");
// antecedent holds -> consequent holds in the next cycle
`define SWMF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swmf assertion failed");
`else
`define SWMF_ASSERT_NOW(label, clk, rst, ante, cons)
`define SWMF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== design/swmf_pkg.sv =====
package swmf_pkg;

   // width of the window_width register
   localparam int CFG_BITS = 5;

   // sort key class, above the sample bits: pads below and above the window
   localparam logic [1:0] KEY_CLASS_LO   = 2'd0;
   localparam logic [1:0] KEY_CLASS_REAL = 2'd1;
   localparam logic [1:0] KEY_CLASS_HI   = 2'd2;

   // per-cycle control broadcast along the cell row
   typedef struct packed {
      logic shift;      // new sample enters the history line
      logic load;       // sort keys load from the history line
      logic sort_en;    // one compare-exchange phase
      logic odd_phase;  // pairs start at odd cell indexes
   } cell_ctl_type;

endpackage

// ===== design/swmf_req_if.sv =====
interface swmf_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample;
   logic                          first;

   modport source (output valid, output sample, output first, input ready);
   modport sink (input valid, input sample, input first, output ready);
endinterface

// ===== design/swmf_rsp_if.sv =====
interface swmf_rsp_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] filtered;
   logic                          passed_through;

   modport source (output valid, output filtered, output passed_through, input ready);
   modport sink (input valid, input filtered, input passed_through, output ready);
endinterface

// ===== design/swmf_csr_if.sv =====
interface swmf_csr_if;
   import swmf_pkg::*;
   logic                valid;
   logic                ready;
   logic [CFG_BITS-1:0] window_width;

   modport source (output valid, output window_width, input ready);
   modport sink (input valid, input window_width, output ready);
endinterface

// ===== design/sliding_window_median_filter.sv =====
// Sliding-window median filter.
// req_ch (sink): one signed sample per request, with first marking the start
// of a new profile. rsp_ch (source): one result per request, in order, with
// filtered and passed_through. csr_ch (sink): writes window_width, always
// ready; write it only while the block is idle.
// Until window_width samples of the profile have come in, the sample goes
// straight back with passed_through set. Otherwise the result is the median
// of the preceding window_width samples (mean of the two middle values,
// rounded toward zero, for an even width).
// Sequence: a passed-through request goes from accept straight to the done
// state, then into the output register, and the block takes the next request
// once back in idle. A filtered request runs the MAX_WINDOW odd-even
// transposition phases over the cell row and a median pick before done.
// Reset clears the profile count, the control state and the output valid,
// and sets window_width to 3. History is not cleared; it is never read before
// it is written.
// A stalled rsp_ch holds its result; the block still accepts and works one
// more request, then waits with that result until the output register frees.
module sliding_window_median_filter
   import swmf_pkg::*;
#(
   parameter int MAX_WINDOW  = 16,
   parameter int SAMPLE_BITS = 16
) (
   input logic         clock,
   input logic         reset,
   swmf_req_if.sink    req_ch,
   swmf_rsp_if.source  rsp_ch,
   swmf_csr_if.sink    csr_ch
);

`include "sliding_window_median_filter_macros.svh"

   localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
   localparam int CMP_BITS = (CNT_BITS > CFG_BITS) ? CNT_BITS : CFG_BITS;
   localparam int KEY_BITS = SAMPLE_BITS + 2;
   localparam int HI_IDX   = MAX_WINDOW / 2;
   localparam int LO_IDX   = (HI_IDX > 0) ? HI_IDX - 1 : 0;
   localparam logic [CNT_BITS-1:0] WIN_MAX    = CNT_BITS'(MAX_WINDOW);
   localparam logic [CNT_BITS-1:0] HALF_WIN   = CNT_BITS'(MAX_WINDOW / 2);
   localparam logic [CNT_BITS-1:0] LAST_PHASE = CNT_BITS'(MAX_WINDOW - 1);

   // control states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SORT = 2'd1;
   localparam logic [1:0] ST_MED  = 2'd2;
   localparam logic [1:0] ST_DONE = 2'd3;

   logic [CFG_BITS-1:0]    window_width_ff, window_width_in;
   logic [1:0]             state_ff, state_in;
   logic [CNT_BITS-1:0]    seen_ff, seen_in;
   logic [CNT_BITS-1:0]    phase_ff, phase_in;
   logic                   w_odd_ff, w_odd_in;
   logic [SAMPLE_BITS-1:0] result_ff, result_in;
   logic                   pass_ff, pass_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                   rsp_pass_ff, rsp_pass_in;

   logic                   req_fire, out_free, pass_now;
   logic [CMP_BITS-1:0]    cfg_ext;
   logic [CNT_BITS-1:0]    eff_width, lo_end, seen_base;
   logic [SAMPLE_BITS-1:0] med_lo, med_hi, median;
   logic [SAMPLE_BITS:0]   mid_sum, mid_adj;
   cell_ctl_type           ctl;

   logic [SAMPLE_BITS-1:0] hist_chain [MAX_WINDOW+1];
   logic [KEY_BITS-1:0]    key_chain  [MAX_WINDOW];

   // ---------------- handshakes ----------------
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.filtered       = rsp_data_ff;
   assign rsp_ch.passed_through = rsp_pass_ff;

   // ---------------- window width and profile count ----------------
   always_comb begin
      window_width_in = window_width_ff;
      if (csr_ch.valid && csr_ch.ready) begin
         window_width_in = csr_ch.window_width;
      end

      // zero acts as one, anything past the bound as the bound
      cfg_ext = CMP_BITS'(window_width_ff);
      if (cfg_ext == '0) begin
         eff_width = CNT_BITS'(1);
      end else if (cfg_ext > CMP_BITS'(MAX_WINDOW)) begin
         eff_width = WIN_MAX;
      end else begin
         eff_width = cfg_ext[CNT_BITS-1:0];
      end

      // low pads so the middle values land on cells LO_IDX / HI_IDX
      lo_end = eff_width + (HALF_WIN - (eff_width >> 1));

      seen_base = req_ch.first ? '0 : seen_ff;
      pass_now  = seen_base < eff_width;

      seen_in = seen_ff;
      if (req_fire) begin
         seen_in = (seen_base == WIN_MAX) ? seen_base : seen_base + CNT_BITS'(1);
      end
   end

   // ---------------- cell row ----------------
   // hist_chain[i] is the sample of age i; a request shifts it down one cell.
   assign hist_chain[0] = req_ch.sample;

   always_comb begin
      ctl.shift     = req_fire;
      ctl.load      = req_fire;
      ctl.sort_en   = (state_ff == ST_SORT);
      ctl.odd_phase = phase_ff[0];
   end

   for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
      localparam int LEFT_IDX  = (i > 0) ? i - 1 : 0;
      localparam int RIGHT_IDX = (i + 1 < MAX_WINDOW) ? i + 1 : i;

      swmf_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .CELL_IDX    (i),
         .CELL_COUNT  (MAX_WINDOW),
         .CNT_BITS    (CNT_BITS)
      ) u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .win_width (eff_width),
         .lo_end    (lo_end),
         .hist_left (hist_chain[i]),
         .hist_q    (hist_chain[i+1]),
         .key_left  (key_chain[LEFT_IDX]),
         .key_right (key_chain[RIGHT_IDX]),
         .key_q     (key_chain[i])
      );
   end

   // ---------------- median pick ----------------
   always_comb begin
      med_lo  = {~key_chain[LO_IDX][SAMPLE_BITS-1], key_chain[LO_IDX][SAMPLE_BITS-2:0]};
      med_hi  = {~key_chain[HI_IDX][SAMPLE_BITS-1], key_chain[HI_IDX][SAMPLE_BITS-2:0]};
      mid_sum = {med_lo[SAMPLE_BITS-1], med_lo} + {med_hi[SAMPLE_BITS-1], med_hi};
      // add one to a negative sum before the shift: rounds toward zero
      mid_adj = mid_sum + {{SAMPLE_BITS{1'b0}}, mid_sum[SAMPLE_BITS]};
      median  = w_odd_ff ? med_hi : mid_adj[SAMPLE_BITS:1];
   end

   // ---------------- sequencer ----------------
   always_comb begin
      state_in  = state_ff;
      phase_in  = phase_ff;
      w_odd_in  = w_odd_ff;
      result_in = result_ff;
      pass_in   = pass_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               result_in = req_ch.sample;
               pass_in   = pass_now;
               w_odd_in  = eff_width[0];
               phase_in  = '0;
               state_in  = pass_now ? ST_DONE : ST_SORT;
            end
         end
         ST_SORT: begin
            phase_in = phase_ff + CNT_BITS'(1);
            if (phase_ff == LAST_PHASE) begin
               state_in = ST_MED;
            end
         end
         ST_MED: begin
            result_in = median;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- output register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_pass_in  = rsp_pass_ff;
      if ((state_ff == ST_DONE) && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result_ff;
         rsp_pass_in  = pass_ff;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_width_ff <= CFG_BITS'(3);
         state_ff        <= ST_IDLE;
         seen_ff         <= '0;
         phase_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         window_width_ff <= window_width_in;
         state_ff        <= state_in;
         seen_ff         <= seen_in;
         phase_ff        <= phase_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      w_odd_ff    <= w_odd_in;
      result_ff   <= result_in;
      pass_ff     <= pass_in;
      rsp_data_ff <= rsp_data_in;
      rsp_pass_ff <= rsp_pass_in;
   end

   // ---------------- checks ----------------
   `SWMF_ASSERT_NEXT(a_req_leaves_idle, clock, reset, req_fire, state_ff != ST_IDLE)
   `SWMF_ASSERT_NEXT(a_pass_skips_sort, clock, reset, req_fire && pass_now,
                     (state_ff == ST_DONE) && pass_ff)
   `SWMF_ASSERT_NEXT(a_sort_ends, clock, reset,
                     (state_ff == ST_SORT) && (phase_ff == LAST_PHASE), state_ff == ST_MED)
   `SWMF_ASSERT_NEXT(a_done_to_rsp, clock, reset, (state_ff == ST_DONE) && out_free,
                     rsp_valid_ff && (state_ff == ST_IDLE))
   `SWMF_ASSERT_NOW(a_seen_bound, clock, reset, 1'b1, seen_ff <= WIN_MAX)

endmodule

// ===== design/swmf_cell.sv =====
// One cell: a history tap plus a sort key that compare-exchanges with a neighbor.
module swmf_cell
   import swmf_pkg::*;
#(
   parameter int SAMPLE_BITS = 16,
   parameter int CELL_IDX    = 0,
   parameter int CELL_COUNT  = 16,
   parameter int CNT_BITS    = 5
) (
   input  logic                     clock,
   input  cell_ctl_type             ctl,
   input  logic [CNT_BITS-1:0]      win_width,
   input  logic [CNT_BITS-1:0]      lo_end,
   input  logic [SAMPLE_BITS-1:0]   hist_left,
   output logic [SAMPLE_BITS-1:0]   hist_q,
   input  logic [SAMPLE_BITS+1:0]   key_left,
   input  logic [SAMPLE_BITS+1:0]   key_right,
   output logic [SAMPLE_BITS+1:0]   key_q
);

   localparam logic [CNT_BITS-1:0] IDX = CNT_BITS'(CELL_IDX);
   localparam bit IDX_ODD   = (CELL_IDX % 2) == 1;
   localparam bit HAS_LEFT  = CELL_IDX > 0;
   localparam bit HAS_RIGHT = (CELL_IDX + 1) < CELL_COUNT;

   logic [SAMPLE_BITS-1:0] hist_ff, hist_in;
   logic [SAMPLE_BITS+1:0] key_ff, key_in, load_key;
   logic [1:0]             key_class;
   logic                   is_lower, is_upper;

   always_comb begin
      // cell index is the sample age: age < width is in the window
      if (IDX < win_width) begin
         key_class = KEY_CLASS_REAL;
      end else if (IDX < lo_end) begin
         key_class = KEY_CLASS_LO;
      end else begin
         key_class = KEY_CLASS_HI;
      end
      // flip the sign bit so an unsigned compare orders signed samples;
      // pads carry no sample bits, their tap may never have been written
      if (key_class == KEY_CLASS_REAL) begin
         load_key = {key_class, ~hist_ff[SAMPLE_BITS-1], hist_ff[SAMPLE_BITS-2:0]};
      end else begin
         load_key = {key_class, {SAMPLE_BITS{1'b0}}};
      end

      is_lower = HAS_RIGHT && (IDX_ODD == ctl.odd_phase);
      is_upper = HAS_LEFT && (IDX_ODD != ctl.odd_phase);

      key_in = key_ff;
      if (ctl.load) begin
         key_in = load_key;
      end else if (ctl.sort_en) begin
         if (is_lower && (key_right < key_ff)) begin
            key_in = key_right;
         end else if (is_upper && (key_left > key_ff)) begin
            key_in = key_left;
         end
      end

      hist_in = ctl.shift ? hist_left : hist_ff;
   end

   always_ff @(posedge clock) begin
      hist_ff <= hist_in;
      key_ff  <= key_in;
   end

   assign hist_q = hist_ff;
   assign key_q  = key_ff;

endmodule

// ===== bench/tb_sliding_window_median_filter.sv =====
`timescale 1ns / 1ps

module tb_sliding_window_median_filter;
   import swmf_pkg::CFG_BITS;

   localparam int MAX_WINDOW   = 16;
   localparam int SAMPLE_BITS  = 16;
   // drain time covers a filtered request's sort with margin
   localparam int DRAIN_CYCLES = 2 * MAX_WINDOW + 8;
   // ~1700 requests plus pauses, taken several times over
   localparam int CYCLE_LIMIT  = 400000;
   localparam int LONG_STALL   = 300;
   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS  = 140;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          first;
   } sample_req_type;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] filtered;
      logic                          passed_through;
   } filter_result_type;

   logic clock = 1'b0;
   logic reset;

   swmf_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_ch ();
   swmf_rsp_if #(.SAMPLE_BITS(SAMPLE_BITS)) rsp_ch ();
   swmf_csr_if                              csr_ch ();

   sliding_window_median_filter #(
      .MAX_WINDOW (MAX_WINDOW),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_top (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch),
      .csr_ch(csr_ch)
   );

   // 2 ns period
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // requests waiting for the driver, results waiting for the block
   sample_req_type    sample_backlog[$];
   filter_result_type predicted_outputs[$];

   // shadow of the block: window width, sample ring, profile count, ring head
   logic [CFG_BITS-1:0]           cfg_width;
   logic signed [SAMPLE_BITS-1:0] sample_ring[MAX_WINDOW];
   int                            profile_count;
   int                            ring_head;

   int   send_idle_pct;
   int   recv_idle_pct;
   logic rsp_hold;
   logic pressure_go;
   logic req_taken;
   int   mismatch_count;
   int   cycle_count;

   // Median of the width samples before this one; this sample joins the
   // ring afterwards. Width 0 acts as 1, anything past MAX_WINDOW as MAX_WINDOW.
   function automatic filter_result_type predict_median(
         logic signed [SAMPLE_BITS-1:0] sample, logic first);
      filter_result_type res;
      int win;
      int vals[MAX_WINDOW];
      int pos;
      int key;
      int j;
      win = (cfg_width == 0) ? 1 : (cfg_width > MAX_WINDOW) ? MAX_WINDOW : int'(cfg_width);
      if (first)
         profile_count = 0;
      if (profile_count < win) begin
         res.filtered       = sample;
         res.passed_through = 1'b1;
      end else begin
         pos = ring_head;
         for (int i = 0; i < win; i++) begin
            pos     = (pos == 0) ? MAX_WINDOW - 1 : pos - 1;
            vals[i] = int'(sample_ring[pos]);
         end
         for (int i = 1; i < win; i++) begin
            key = vals[i];
            j   = i;
            while (j > 0 && vals[j-1] > key) begin
               vals[j] = vals[j-1];
               j--;
            end
            vals[j] = key;
         end
         // even width: mean of middle pair, int division truncates toward zero
         if (win % 2 == 0)
            res.filtered = SAMPLE_BITS'((vals[win/2-1] + vals[win/2]) / 2);
         else
            res.filtered = SAMPLE_BITS'(vals[win/2]);
         res.passed_through = 1'b0;
      end
      sample_ring[ring_head] = sample;
      ring_head = (ring_head + 1) % MAX_WINDOW;
      if (profile_count < MAX_WINDOW)
         profile_count++;
      return res;
   endfunction

   function automatic void queue_request(logic first, logic signed [SAMPLE_BITS-1:0] sample);
      sample_req_type item;
      item.sample = sample;
      item.first  = first;
      sample_backlog.push_back(item);
   endfunction

   // sample content per profile style: wide random, clustered (duplicates),
   // rail values, or wide random salted with rails
   function automatic logic signed [SAMPLE_BITS-1:0] random_level(int style, int base);
      logic signed [SAMPLE_BITS-1:0] rails[6];
      rails = '{16'sh7fff, 16'sh8000, 16'sh7ffe, 16'sh8001, 16'sh0000, 16'shffff};
      case (style)
         0: begin
            return SAMPLE_BITS'($urandom);
         end
         1: begin
            return SAMPLE_BITS'(base + int'($urandom_range(0, 15)) - 8);
         end
         2: begin
            return rails[$urandom_range(0, 5)];
         end
         default: begin
            if ($urandom_range(0, 3) == 0)
               return rails[$urandom_range(0, 5)];
            return SAMPLE_BITS'($urandom);
         end
      endcase
   endfunction

   // Mostly well-formed profiles (first flag on the opening request) with random
   // lengths, so long runs saturate the count; a few short ones and stray flags.
   // The opening profile of a phase may carry on the previous one, which
   // exercises a width change in mid-profile.
   task automatic queue_profiles(int n_items);
      int left;
      int len;
      int style;
      int base;
      logic flag;
      left = n_items;
      while (left > 0) begin
         len   = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 45);
         len   = (len > left) ? left : len;
         style = $urandom_range(0, 3);
         base  = int'($urandom_range(0, 65535)) - 32768;
         for (int k = 0; k < len; k++) begin
            if (k == 0)
               flag = (left == n_items) ? 1'($urandom_range(0, 1)) : 1'b1;
            else
               flag = ($urandom_range(0, 15) == 0);
            queue_request(flag, random_level(style, base));
         end
         left -= len;
      end
   endtask

   // register write, only issued while the block is idle
   task automatic write_window_width(logic [CFG_BITS-1:0] width);
      @(negedge clock);
      csr_ch.valid        <= 1'b1;
      csr_ch.window_width <= width;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // wait for every request to be taken and answered, then let the block drain
   task automatic settle();
      while (sample_backlog.size() != 0 || req_ch.valid || predicted_outputs.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // request driver: hold valid until taken, gaps only between requests
   always @(negedge clock) begin
      sample_req_type item;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (sample_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            item = sample_backlog.pop_front();
            req_ch.valid  <= 1'b1;
            req_ch.sample <= item.sample;
            req_ch.first  <= item.first;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      rsp_ch.ready <= rsp_hold ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // long receiver hold-off while the sender keeps offering: block fills up
   // and must back-pressure the request side
   initial begin
      rsp_hold = 1'b0;
      wait (pressure_go);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (LONG_STALL) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // monitor: register writes and requests update the shadow at the accepting
   // edge; results are checked in order
   always @(posedge clock) begin
      filter_result_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (csr_ch.valid && csr_ch.ready)
            cfg_width = csr_ch.window_width;
         if (req_ch.valid && req_ch.ready) begin
            req_taken = 1'b1;
            predicted_outputs.push_back(predict_median(req_ch.sample, req_ch.first));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (predicted_outputs.size() == 0) begin
               $error("result with no request outstanding: filtered %0d", rsp_ch.filtered);
               mismatch_count++;
            end else begin
               want = predicted_outputs.pop_front();
               if (rsp_ch.filtered !== want.filtered) begin
                  $error("filtered: expected %0d, actual %0d", want.filtered, rsp_ch.filtered);
                  mismatch_count++;
               end
               if (rsp_ch.passed_through !== want.passed_through) begin
                  $error("passed_through: expected %0b, actual %0b",
                         want.passed_through, rsp_ch.passed_through);
                  mismatch_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("sliding_window_median_filter regression: fail");
         $finish;
      end
   end

   initial begin
      logic [CFG_BITS-1:0] phase_widths[RANDOM_PHASES];
      phase_widths = '{5'd1, 5'd2, 5'd3, 5'd4, 5'd16, 5'd31, 5'd5, 5'd8,
                       5'd0, 5'd17, 5'd15, 5'($urandom_range(0, 31))};

      reset               = 1'b1;
      req_ch.valid        = 1'b0;
      req_ch.sample       = '0;
      req_ch.first        = 1'b0;
      rsp_ch.ready        = 1'b0;
      csr_ch.valid        = 1'b0;
      csr_ch.window_width = '0;
      cfg_width           = 5'd3;
      profile_count       = 0;
      ring_head           = 0;
      req_taken           = 1'b0;
      pressure_go         = 1'b0;
      mismatch_count      = 0;
      cycle_count         = 0;
      send_idle_pct       = 21;
      recv_idle_pct       = 48;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset width 3: rails through the window, then a restart mid-stream
      queue_request(1'b1, 16'sh7fff);
      queue_request(1'b0, 16'sh8000);
      queue_request(1'b0, 16'sh0000);
      queue_request(1'b0, 16'shffff);
      queue_request(1'b0, 16'sh0001);
      queue_request(1'b0, 16'sd12345);
      queue_request(1'b1, -16'sd5);
      queue_request(1'b0, 16'sd7);
      settle();

      // even width: mean rounds toward zero, no overflow at the rails
      write_window_width(5'd2);
      queue_request(1'b1, -16'sd3);
      queue_request(1'b0, 16'sd0);
      queue_request(1'b0, 16'sd9);
      queue_request(1'b0, 16'sh7fff);
      queue_request(1'b0, 16'sh7fff);
      queue_request(1'b0, 16'sh8000);
      queue_request(1'b0, 16'sh8000);
      queue_request(1'b0, 16'sd100);
      settle();

      // width 0 behaves as 1: previous sample echoed
      write_window_width(5'd0);
      queue_request(1'b1, 16'sd42);
      queue_request(1'b0, -16'sd7);
      queue_request(1'b0, 16'sh7fff);
      queue_request(1'b1, 16'sd0);
      settle();

      // random phases: sender/receiver idling, then swapped, then none
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p < RANDOM_PHASES / 3) begin
            send_idle_pct = 21;
            recv_idle_pct = 48;
         end else if (p < 2 * RANDOM_PHASES / 3) begin
            send_idle_pct = 48;
            recv_idle_pct = 21;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_window_width(phase_widths[p]);
         if (p == 2 * RANDOM_PHASES / 3)
            pressure_go = 1'b1;
         queue_profiles(PHASE_ITEMS);
         settle();
      end

      if (mismatch_count == 0)
         $display("sliding_window_median_filter regression: pass");
      else
         $display("sliding_window_median_filter regression: fail");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/swmf_pkg.sv
design/swmf_req_if.sv
design/swmf_rsp_if.sv
design/swmf_csr_if.sv
design/swmf_cell.sv
design/sliding_window_median_filter.sv
bench/tb_sliding_window_median_filter.sv
